// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the base64 stream encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Asserts that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/b64se_pkg.sv =====
// Package with the types, character codes and alphabet function of the base64 stream encoder.
`default_nettype none

package b64se_pkg;

    localparam int GROUP_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    localparam logic [1:0] RUN_ONE   = 2'd0;
    localparam logic [1:0] RUN_TWO   = 2'd1;
    localparam logic [1:0] RUN_THREE = 2'd2;
    localparam logic [1:0] RUN_FOUR  = 2'd3;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    // One queued run of up to four characters caused by one input byte.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] sextet(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            r = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            r = 8'd43;
        end else begin
            r = 8'd47;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64se_front.sv =====
// Front end: accepts message bytes, tracks the group state and builds character runs.
`default_nettype none

module b64se_front
    import b64se_pkg::*;
#(
    parameter int LINE_CHARS = 76
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    input  wire q_stat_t    q_stat,
    output logic            q_push,
    output run_t            q_wr_run
);

    localparam int LINE_GROUPS = LINE_CHARS / 4;
    localparam logic [GROUP_W:0] LINE_GROUPS_W = (GROUP_W + 1)'(LINE_GROUPS);

    phase_t               phase_reg, phase_next;
    logic [3:0]           carry_reg, carry_next;
    logic [GROUP_W-1:0]   groups_reg, groups_next;
    logic [GROUP_W:0]     groups_inc;

    assign s_ready    = !q_stat.full;
    assign q_push     = s_valid && !q_stat.full;
    assign groups_inc = {1'b0, groups_reg} + (GROUP_W + 1)'(1);

    always_comb begin
        q_wr_run     = '0;
        q_wr_run.fin = s_final_byte;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        groups_next  = groups_reg;
        case (phase_reg)
            PH_SECOND: begin
                q_wr_run.chars[0] = sextet({carry_reg[1:0], s_data_byte[7:4]});
                carry_next = s_data_byte[3:0];
                phase_next = PH_THIRD;
                if (s_final_byte) begin
                    q_wr_run.chars[1] = sextet({s_data_byte[3:0], 2'b00});
                    q_wr_run.chars[2] = CHAR_PAD;
                    q_wr_run.last_idx = RUN_THREE;
                end else begin
                    q_wr_run.last_idx = RUN_ONE;
                end
            end
            PH_THIRD: begin
                q_wr_run.chars[0] = sextet({carry_reg, s_data_byte[7:6]});
                q_wr_run.chars[1] = sextet(s_data_byte[5:0]);
                carry_next = 4'd0;
                phase_next = PH_FIRST;
                if (groups_inc >= LINE_GROUPS_W) begin
                    q_wr_run.chars[2] = CHAR_CR;
                    q_wr_run.chars[3] = CHAR_LF;
                    q_wr_run.last_idx = RUN_FOUR;
                    groups_next = '0;
                end else begin
                    q_wr_run.last_idx = RUN_TWO;
                    groups_next = groups_inc[GROUP_W-1:0];
                end
            end
            default: begin
                q_wr_run.chars[0] = sextet(s_data_byte[7:2]);
                carry_next = {2'b00, s_data_byte[1:0]};
                phase_next = PH_SECOND;
                if (s_final_byte) begin
                    q_wr_run.chars[1] = sextet({s_data_byte[1:0], 4'b0000});
                    q_wr_run.chars[2] = CHAR_PAD;
                    q_wr_run.chars[3] = CHAR_PAD;
                    q_wr_run.last_idx = RUN_FOUR;
                end else begin
                    q_wr_run.last_idx = RUN_ONE;
                end
            end
        endcase
        if (s_final_byte) begin
            phase_next  = PH_FIRST;
            carry_next  = 4'd0;
            groups_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            carry_reg  <= 4'd0;
            groups_reg <= '0;
        end else if (q_push) begin
            phase_reg  <= phase_next;
            carry_reg  <= carry_next;
            groups_reg <= groups_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64se_queue.sv =====
// Short queue of character runs between the front end and the output serializer.
`default_nettype none

module b64se_queue
    import b64se_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire run_t wr_run,
    input  wire logic pop,
    output run_t      rd_run,
    output q_stat_t   stat
);

    run_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_run     = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= wr_run;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64se_back.sv =====
// Back end: serializes queued runs into one output character per transaction.
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire run_t       q_rd_run,
    input  wire q_stat_t    q_stat,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_run_last,
    output logic            m_message_end
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] char_reg, char_next;
    logic       run_last_reg, run_last_next;
    logic       msg_end_reg, msg_end_next;
    logic       load, at_last;

    assign load    = !q_stat.empty && (!valid_reg || m_ready);
    assign at_last = (idx_reg == q_rd_run.last_idx);
    assign q_pop   = load && at_last;

    always_comb begin
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        char_next     = char_reg;
        run_last_next = run_last_reg;
        msg_end_next  = msg_end_reg;
        if (load) begin
            valid_next    = 1'b1;
            idx_next      = at_last ? 2'd0 : idx_reg + 2'd1;
            char_next     = q_rd_run.chars[idx_reg];
            run_last_next = at_last;
            msg_end_next  = at_last && q_rd_run.fin;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        run_last_reg <= run_last_next;
        msg_end_reg  <= msg_end_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_char    = char_reg;
    assign m_run_last    = run_last_reg;
    assign m_message_end = msg_end_reg;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// Base64 stream encoder with MIME line breaks: one byte in, one character out per transaction.
// A message byte is taken whenever the two-entry run queue has room, and it
// yields one to four output characters (base64 characters, '=' pads, or CR LF after a group
// that fills a line of LINE_CHARS characters rounded down to whole groups). Characters leave
// through a single output register at one per cycle while m_ready is high; the sustained
// input rate is therefore set by the output character count, line breaks included.
// The input side keeps accepting while earlier characters are still waiting to be taken.
// After a byte flagged final, all group and line state returns to its start for the next message.
`default_nettype none

module base64_stream_encoder
    import b64se_pkg::*;
#(
    parameter int LINE_CHARS = 76
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_run_last,
    output logic            m_message_end
);

    q_stat_t q_stat;
    run_t    q_wr_run;
    run_t    q_rd_run;
    logic    q_push;
    logic    q_pop;

    b64se_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_wr_run     (q_wr_run)
    );

    b64se_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_run  (q_wr_run),
        .pop     (q_pop),
        .rd_run  (q_rd_run),
        .stat    (q_stat)
    );

    b64se_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_rd_run      (q_rd_run),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_last    (m_run_last),
        .m_message_end (m_message_end)
    );

endmodule

`default_nettype wire

// ===== rtl/b64se_checker.sv =====
// Port-level checker for the base64 stream encoder and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module b64se_checker
    import b64se_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_data_byte,
    input wire logic       s_final_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_char,
    input wire logic       m_run_last,
    input wire logic       m_message_end
);

    logic char_ok;
    logic m_fire;
    logic s_seen;

    assign m_fire  = m_valid && m_ready;
    assign s_seen  = s_valid || s_ready || s_final_byte || (s_data_byte != 8'd0);
    assign char_ok = ((m_out_char >= 8'd65) && (m_out_char <= 8'd90))
                  || ((m_out_char >= 8'd97) && (m_out_char <= 8'd122))
                  || ((m_out_char >= 8'd48) && (m_out_char <= 8'd57))
                  || (m_out_char == 8'd43) || (m_out_char == 8'd47)
                  || (m_out_char == CHAR_PAD) || (m_out_char == CHAR_CR)
                  || (m_out_char == CHAR_LF);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_run_last) && $stable(m_message_end), "Stalled output transaction changed")
    `ASSERT_NEVER(a_end_without_last, aclk, aresetn, m_valid && m_message_end && !m_run_last, "Message end on a character that does not end its run")
    `ASSERT_NEVER(a_bad_char, aclk, aresetn, m_valid && !char_ok && (s_seen || !s_seen), "Output character outside the base64 set")
    `ASSERT_CLK(a_cr_then_lf, aclk, aresetn, m_fire && (m_out_char == CHAR_CR) |=> m_valid && (m_out_char == CHAR_LF), "CR not followed at once by LF")
    `ASSERT_CLK(a_pad_ends_msg, aclk, aresetn, m_valid && (m_out_char == CHAR_PAD) && m_run_last |-> m_message_end, "Final pad character without message end")

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_data_byte   (s_data_byte),
    .s_final_byte  (s_final_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_char    (m_out_char),
    .m_run_last    (m_run_last),
    .m_message_end (m_message_end)
);

`default_nettype wire
